### hdl/tffc_pkg.sv
// ---------------------------------------------------------------------------
// Thermal filter / fan curve package
// Shared widths, constants, register indexes, status codes and the
// command/status bundles between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package tffc_pkg;

   localparam int ADC_W      = 12;
   localparam int TEMP_W     = 18;
   localparam int THR_W      = 19;
   localparam int DUTY_W     = 7;
   localparam int MDUTY_W    = 8;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 19;

   // ADC code to millivolts: raw * 3300 >> 12
   localparam int MV_SCALE   = 3300;
   localparam int PROD_W     = 24;
   localparam int MV_W       = 12;
   localparam int MV30_W     = 17;
   localparam int DEG_PER_MV = 30;
   localparam int TEMP_OFFSET = 125000;
   localparam int ACC_RESET  = 25000;

   localparam int DUTY_HALF  = 50;
   localparam int DUTY_FULL  = 100;

   // fan curve divider: quotient stays below 50, six bits
   localparam int QUO_W      = 6;
   localparam int CNT_W      = 3;
   localparam int NUM_W      = 25;
   localparam int DSH_W      = THR_W + QUO_W - 1;

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD_LOW      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD_MID      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD_HIGH     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD_CRITICAL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MANUAL_MODE        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MANUAL_DUTY        = 3'd5;

   localparam logic signed [THR_W-1:0] THR_LOW_RESET  = 19'sd30000;
   localparam logic signed [THR_W-1:0] THR_MID_RESET  = 19'sd45000;
   localparam logic signed [THR_W-1:0] THR_HIGH_RESET = 19'sd60000;
   localparam logic signed [THR_W-1:0] THR_CRIT_RESET = 19'sd80000;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_NORMAL   = 2'd0,
      STATUS_WARNING  = 2'd1,
      STATUS_CRITICAL = 2'd2,
      STATUS_MANUAL   = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [THR_W-1:0] threshold_low;
      logic signed [THR_W-1:0] threshold_mid;
      logic signed [THR_W-1:0] threshold_high;
      logic signed [THR_W-1:0] threshold_critical;
      logic                    manual_mode;
      logic [MDUTY_W-1:0]      manual_duty;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic mult;
      logic conv;
      logic filt;
      logic setup;
      logic div_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } sts_type;

endpackage

`default_nettype wire

### hdl/tffc_req_if.sv
// ---------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one ADC code and one internal temperature.
// ---------------------------------------------------------------------------
`default_nettype none

interface tffc_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [tffc_pkg::ADC_W-1:0]            adc_raw;
   logic signed [tffc_pkg::TEMP_W-1:0]    int_temp_raw;

   modport source (output valid, output adc_raw, output int_temp_raw, input ready);
   modport sink   (input valid, input adc_raw, input int_temp_raw, output ready);
endinterface

`default_nettype wire

### hdl/tffc_rsp_if.sv
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying filtered temperatures, fan duty and status.
// ---------------------------------------------------------------------------
`default_nettype none

interface tffc_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [tffc_pkg::TEMP_W-1:0]    ext_temp_filtered;
   logic signed [tffc_pkg::TEMP_W-1:0]    int_temp_filtered;
   logic [tffc_pkg::DUTY_W-1:0]           fan_duty;
   logic [tffc_pkg::STATUS_W-1:0]         status;

   modport source (output valid, output ext_temp_filtered, output int_temp_filtered,
                   output fan_duty, output status, input ready);
   modport sink   (input valid, input ext_temp_filtered, input int_temp_filtered,
                   input fan_duty, input status, output ready);
endinterface

`default_nettype wire

### hdl/tffc_regs.sv
// ---------------------------------------------------------------------------
// Configuration registers
// Thresholds and manual fan control, written through a plain write port.
// ---------------------------------------------------------------------------
`default_nettype none

module tffc_regs (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [tffc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tffc_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output tffc_pkg::cfg_type                      cfg
);

   tffc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            tffc_pkg::REG_THRESHOLD_LOW:
               cfg_in.threshold_low = csr_wdata[tffc_pkg::THR_W-1:0];
            tffc_pkg::REG_THRESHOLD_MID:
               cfg_in.threshold_mid = csr_wdata[tffc_pkg::THR_W-1:0];
            tffc_pkg::REG_THRESHOLD_HIGH:
               cfg_in.threshold_high = csr_wdata[tffc_pkg::THR_W-1:0];
            tffc_pkg::REG_THRESHOLD_CRITICAL:
               cfg_in.threshold_critical = csr_wdata[tffc_pkg::THR_W-1:0];
            tffc_pkg::REG_MANUAL_MODE:
               cfg_in.manual_mode = csr_wdata[0];
            tffc_pkg::REG_MANUAL_DUTY:
               cfg_in.manual_duty = csr_wdata[tffc_pkg::MDUTY_W-1:0];
            default: begin
               // drop writes beyond the register list
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_low      <= tffc_pkg::THR_LOW_RESET;
         cfg_ff.threshold_mid      <= tffc_pkg::THR_MID_RESET;
         cfg_ff.threshold_high     <= tffc_pkg::THR_HIGH_RESET;
         cfg_ff.threshold_critical <= tffc_pkg::THR_CRIT_RESET;
         cfg_ff.manual_mode        <= 1'b0;
         cfg_ff.manual_duty        <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### hdl/tffc_ctrl.sv
// ---------------------------------------------------------------------------
// Thermal filter controller
// Sequences one sample through convert, filter, curve setup and divide.
// ---------------------------------------------------------------------------
`default_nettype none

module tffc_ctrl (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output tffc_pkg::cmd_type cmd,
   input  wire tffc_pkg::sts_type sts
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MULT  = 7'b0000010,
      ST_CONV  = 7'b0000100,
      ST_FILT  = 7'b0001000,
      ST_SETUP = 7'b0010000,
      ST_DIV   = 7'b0100000,
      ST_DONE  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = ST_CONV;
         end
         ST_CONV: begin
            cmd.conv = 1'b1;
            state_in = ST_FILT;
         end
         ST_FILT: begin
            cmd.filt = 1'b1;
            state_in = ST_SETUP;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### hdl/tffc_dp.sv
// ---------------------------------------------------------------------------
// Thermal filter datapath
// ADC conversion, two IIR filters, fan curve with a restoring divider,
// status selection and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tffc_dp #(
   parameter int ALPHA_SHIFT = 3
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire tffc_pkg::cmd_type                      cmd,
   output tffc_pkg::sts_type                           sts,
   input  wire tffc_pkg::cfg_type                      cfg,
   input  wire logic [tffc_pkg::ADC_W-1:0]             req_adc_raw,
   input  wire logic signed [tffc_pkg::TEMP_W-1:0]     req_int_temp_raw,
   output logic signed [tffc_pkg::TEMP_W-1:0]          rsp_ext_temp_filtered,
   output logic signed [tffc_pkg::TEMP_W-1:0]          rsp_int_temp_filtered,
   output logic [tffc_pkg::DUTY_W-1:0]                 rsp_fan_duty,
   output logic [tffc_pkg::STATUS_W-1:0]               rsp_status
);

   localparam int TW = tffc_pkg::TEMP_W;
   localparam int CW = tffc_pkg::THR_W + 1;

   logic [tffc_pkg::ADC_W-1:0]    adc_ff, adc_in;
   logic signed [TW-1:0]          int_raw_ff, int_raw_in;
   logic [tffc_pkg::PROD_W-1:0]   prod_ff, prod_in;
   logic signed [TW-1:0]          ext_mc_ff, ext_mc_in;
   logic signed [TW-1:0]          ext_acc_ff, ext_acc_in;
   logic signed [TW-1:0]          int_acc_ff, int_acc_in;
   logic [tffc_pkg::NUM_W-1:0]    rem_ff, rem_in;
   logic [tffc_pkg::DSH_W-1:0]    dsh_ff, dsh_in;
   logic [tffc_pkg::QUO_W-1:0]    quo_ff, quo_in;
   logic [tffc_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [tffc_pkg::DUTY_W-1:0]   base_ff, base_in;
   tffc_pkg::status_type          status_ff, status_in;

   logic signed [TW-1:0]          out_ext_ff, out_ext_in;
   logic signed [TW-1:0]          out_int_ff, out_int_in;
   logic [tffc_pkg::DUTY_W-1:0]   out_duty_ff, out_duty_in;
   tffc_pkg::status_type          out_status_ff, out_status_in;

   logic [tffc_pkg::MV_W-1:0]     mv;
   logic [tffc_pkg::MV30_W-1:0]   mv_x30;
   logic [tffc_pkg::MV30_W-1:0]   conv_u;
   logic signed [TW:0]            ext_diff, ext_step, ext_sum;
   logic signed [TW:0]            int_diff, int_step, int_sum;
   logic signed [CW-1:0]          t_w, lo_w, mid_w, hi_w, crit_w;
   logic signed [CW-1:0]          d_lo, d_mid, span_lo, span_hi;
   logic [tffc_pkg::THR_W-1:0]    seg_offset, divisor;
   logic [tffc_pkg::DUTY_W-1:0]   manual_clamped;
   logic                          div_ge;

   // conversion
   assign mv      = prod_ff[tffc_pkg::PROD_W-1 -: tffc_pkg::MV_W];
   assign mv_x30  = tffc_pkg::MV30_W'({5'd0, mv} * tffc_pkg::MV30_W'(tffc_pkg::DEG_PER_MV));
   assign conv_u  = tffc_pkg::MV30_W'(tffc_pkg::TEMP_OFFSET) - mv_x30;

   // filters: acc + ((x - acc) >>> shift)
   assign ext_diff = {ext_mc_ff[TW-1], ext_mc_ff} - {ext_acc_ff[TW-1], ext_acc_ff};
   assign ext_step = ext_diff >>> ALPHA_SHIFT;
   assign ext_sum  = {ext_acc_ff[TW-1], ext_acc_ff} + ext_step;
   assign int_diff = {int_raw_ff[TW-1], int_raw_ff} - {int_acc_ff[TW-1], int_acc_ff};
   assign int_step = int_diff >>> ALPHA_SHIFT;
   assign int_sum  = {int_acc_ff[TW-1], int_acc_ff} + int_step;

   // curve operands
   assign t_w     = {{(CW-TW){ext_acc_ff[TW-1]}}, ext_acc_ff};
   assign lo_w    = {cfg.threshold_low[tffc_pkg::THR_W-1], cfg.threshold_low};
   assign mid_w   = {cfg.threshold_mid[tffc_pkg::THR_W-1], cfg.threshold_mid};
   assign hi_w    = {cfg.threshold_high[tffc_pkg::THR_W-1], cfg.threshold_high};
   assign crit_w  = {cfg.threshold_critical[tffc_pkg::THR_W-1], cfg.threshold_critical};
   assign d_lo    = t_w - lo_w;
   assign d_mid   = t_w - mid_w;
   assign span_lo = mid_w - lo_w;
   assign span_hi = hi_w - mid_w;

   assign manual_clamped = (cfg.manual_duty > tffc_pkg::MDUTY_W'(tffc_pkg::DUTY_FULL))
                           ? tffc_pkg::DUTY_W'(tffc_pkg::DUTY_FULL)
                           : cfg.manual_duty[tffc_pkg::DUTY_W-1:0];

   always_comb begin
      seg_offset = '0;
      divisor    = tffc_pkg::THR_W'(1);
      base_in    = tffc_pkg::DUTY_W'(0);
      status_in  = tffc_pkg::STATUS_NORMAL;
      if (cfg.manual_mode) begin
         base_in   = manual_clamped;
         status_in = tffc_pkg::STATUS_MANUAL;
      end else begin
         if (t_w < lo_w) begin
            base_in = tffc_pkg::DUTY_W'(0);
         end else if (t_w < mid_w) begin
            seg_offset = d_lo[tffc_pkg::THR_W-1:0];
            divisor    = span_lo[tffc_pkg::THR_W-1:0];
         end else if (t_w < hi_w) begin
            seg_offset = d_mid[tffc_pkg::THR_W-1:0];
            divisor    = span_hi[tffc_pkg::THR_W-1:0];
            base_in    = tffc_pkg::DUTY_W'(tffc_pkg::DUTY_HALF);
         end else begin
            base_in = tffc_pkg::DUTY_W'(tffc_pkg::DUTY_FULL);
         end
         if (t_w >= crit_w) begin
            status_in = tffc_pkg::STATUS_CRITICAL;
         end else if (t_w >= mid_w) begin
            status_in = tffc_pkg::STATUS_WARNING;
         end
      end
      if (!cmd.setup) begin
         base_in   = base_ff;
         status_in = status_ff;
      end
   end

   // restoring divider, one quotient bit per step
   assign div_ge = rem_ff >= tffc_pkg::NUM_W'(dsh_ff);

   always_comb begin
      adc_in      = cmd.capture ? req_adc_raw : adc_ff;
      int_raw_in  = cmd.capture ? req_int_temp_raw : int_raw_ff;
      prod_in     = cmd.mult
                    ? tffc_pkg::PROD_W'({12'd0, adc_ff} *
                                        tffc_pkg::PROD_W'(tffc_pkg::MV_SCALE))
                    : prod_ff;
      ext_mc_in   = cmd.conv ? signed'({1'b0, conv_u}) : ext_mc_ff;
      ext_acc_in  = cmd.filt ? ext_sum[TW-1:0] : ext_acc_ff;
      int_acc_in  = cmd.filt ? int_sum[TW-1:0] : int_acc_ff;

      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (cmd.setup) begin
         rem_in = tffc_pkg::NUM_W'({{(tffc_pkg::NUM_W-tffc_pkg::THR_W){1'b0}}, seg_offset} *
                                   tffc_pkg::NUM_W'(tffc_pkg::DUTY_HALF));
         dsh_in = {divisor, {(tffc_pkg::QUO_W-1){1'b0}}};
         quo_in = '0;
         cnt_in = tffc_pkg::CNT_W'(tffc_pkg::QUO_W - 1);
      end else if (cmd.div_step) begin
         rem_in = div_ge ? rem_ff - tffc_pkg::NUM_W'(dsh_ff) : rem_ff;
         dsh_in = dsh_ff >> 1;
         quo_in = {quo_ff[tffc_pkg::QUO_W-2:0], div_ge};
         cnt_in = cnt_ff - tffc_pkg::CNT_W'(1);
      end

      out_ext_in    = cmd.load_out ? ext_acc_ff : out_ext_ff;
      out_int_in    = cmd.load_out ? int_acc_ff : out_int_ff;
      out_duty_in   = cmd.load_out ? base_ff + {1'b0, quo_ff} : out_duty_ff;
      out_status_in = cmd.load_out ? status_ff : out_status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_acc_ff <= TW'(tffc_pkg::ACC_RESET);
         int_acc_ff <= TW'(tffc_pkg::ACC_RESET);
      end else begin
         ext_acc_ff <= ext_acc_in;
         int_acc_ff <= int_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      adc_ff        <= adc_in;
      int_raw_ff    <= int_raw_in;
      prod_ff       <= prod_in;
      ext_mc_ff     <= ext_mc_in;
      rem_ff        <= rem_in;
      dsh_ff        <= dsh_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      base_ff       <= base_in;
      status_ff     <= status_in;
      out_ext_ff    <= out_ext_in;
      out_int_ff    <= out_int_in;
      out_duty_ff   <= out_duty_in;
      out_status_ff <= out_status_in;
   end

   assign sts.div_last          = (cnt_ff == '0);
   assign rsp_ext_temp_filtered = out_ext_ff;
   assign rsp_int_temp_filtered = out_int_ff;
   assign rsp_fan_duty          = out_duty_ff;
   assign rsp_status            = out_status_ff;

endmodule

`default_nettype wire

### hdl/thermal_filter_fan_curve.sv
// ---------------------------------------------------------------------------
// Thermal filter and fan curve, top level
// Per sample: convert the NTC code to millidegrees, filter both temperatures,
// derive fan duty (auto curve or manual) and a thermal status.
//
// Usage:
//   req_chan  sample beats: adc_raw (12-bit code), int_temp_raw (millidegrees).
//   rsp_chan  one result beat per sample: both filtered temperatures,
//             fan_duty in percent and status (normal/warning/critical/manual).
//   csr_*     write-only registers: thresholds low/mid/high/critical,
//             manual mode and manual duty; write them only while idle.
// Timing:
//   A sample is taken in the idle state and passes through the multiply,
//   convert, filter and curve setup steps, six steps of the restoring divider
//   and the load of the result register, which makes the result valid. The
//   next sample is accepted only once the block is back in the idle state.
//   The result register decouples the two sides: the next sample is accepted
//   while a result waits; a stalled receiver holds the block only when a new
//   result is ready and the old one has not been taken.
// Reset:
//   Both filter accumulators restart at 25000 mC, registers take their
//   default thresholds (30/45/60/80 C), auto mode; no result is pending.
// ---------------------------------------------------------------------------
`default_nettype none

module thermal_filter_fan_curve #(
   parameter int ALPHA_SHIFT = 3
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   tffc_req_if.sink                               req_chan,
   tffc_rsp_if.source                             rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [tffc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tffc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   tffc_pkg::cfg_type cfg;
   tffc_pkg::cmd_type cmd;
   tffc_pkg::sts_type sts;
   logic              req_ready;
   logic              rsp_valid;
   logic [tffc_pkg::STATUS_W-1:0] rsp_status;

   // configuration registers
   tffc_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer: owns the handshakes and steps the datapath
   tffc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   // arithmetic, filter state and result register
   tffc_dp #(
      .ALPHA_SHIFT (ALPHA_SHIFT)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .cfg                   (cfg),
      .req_adc_raw           (req_chan.adc_raw),
      .req_int_temp_raw      (req_chan.int_temp_raw),
      .rsp_ext_temp_filtered (rsp_chan.ext_temp_filtered),
      .rsp_int_temp_filtered (rsp_chan.int_temp_filtered),
      .rsp_fan_duty          (rsp_chan.fan_duty),
      .rsp_status            (rsp_status)
   );

   assign req_chan.ready  = req_ready;
   assign rsp_chan.valid  = rsp_valid;
   assign rsp_chan.status = rsp_status;

endmodule

`default_nettype wire

### tb/sv/thermal_filter_fan_curve_test.sv
// ---------------------------------------------------------------------------
// Thermal filter and fan curve testbench
// Drives sample beats into the block and checks every result beat against a
// cycle-free predictor. The predictor converts the ADC code, filters both
// temperatures and derives fan duty and status. Directed tests cover field
// extremes, the climb through every curve segment, the manual clamp and
// thresholds out of order. Random phases then reprogram the registers while
// the block is idle and send runs of samples, with random gaps and stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module thermal_filter_fan_curve_test;
   import tffc_pkg::*;

   localparam int FILTER_SHIFT = 3;
   localparam int CLK_HALF = 4;
   localparam int RESET_CYCLES = 9;
   // settle time after the last result, with margin
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_PHASES = 13;
   localparam int PHASE_SAMPLES = 92;
   localparam longint RUN_LIMIT = 64'd3_200_000;

   // indexes past the register list; the block must ignore writes to them
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_HI = 3'd7;

   localparam int THR_MIN = -(1 << (THR_W - 1));
   localparam int THR_MAX = (1 << (THR_W - 1)) - 1;

   typedef struct {
      logic signed [TEMP_W-1:0] ext_temp;
      logic signed [TEMP_W-1:0] int_temp;
      logic [DUTY_W-1:0]        duty;
      status_type               status;
   } fan_reading_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tffc_req_if req_chan();
   tffc_rsp_if rsp_chan();

   thermal_filter_fan_curve #(
      .ALPHA_SHIFT(FILTER_SHIFT)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the block's registers and filter accumulators
   cfg_type                  cfg_shadow;
   logic signed [TEMP_W-1:0] ext_acc_shadow;
   logic signed [TEMP_W-1:0] int_acc_shadow;

   // predicted readings, oldest first
   fan_reading_type pending_readings[$];

   bit send_gaps;
   bit recv_stalls;
   int fail_count;
   int samples_sent;
   int readings_checked;
   int settings_applied;

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // Advance both filters by one sample and derive duty and status from the
   // new external value, exactly as the block does for an accepted beat.
   function automatic fan_reading_type predict_reading(input logic [ADC_W-1:0] adc,
                                                       input logic signed [TEMP_W-1:0] itemp);
      fan_reading_type r;
      longint mv;
      longint ext_mc;
      longint t;
      longint lo;
      longint mid;
      longint hi;
      longint crit;
      mv = (longint'(adc) * MV_SCALE) / 4096;
      ext_mc = TEMP_OFFSET - DEG_PER_MV * mv;
      // arithmetic shift of a signed longint rounds toward minus infinity
      ext_acc_shadow = TEMP_W'(longint'(ext_acc_shadow)
                               + ((ext_mc - longint'(ext_acc_shadow)) >>> FILTER_SHIFT));
      int_acc_shadow = TEMP_W'(longint'(int_acc_shadow)
                               + ((longint'(itemp) - longint'(int_acc_shadow)) >>> FILTER_SHIFT));
      r.ext_temp = ext_acc_shadow;
      r.int_temp = int_acc_shadow;
      t    = longint'(ext_acc_shadow);
      lo   = longint'($signed(cfg_shadow.threshold_low));
      mid  = longint'($signed(cfg_shadow.threshold_mid));
      hi   = longint'($signed(cfg_shadow.threshold_high));
      crit = longint'($signed(cfg_shadow.threshold_critical));
      if (cfg_shadow.manual_mode) begin
         r.duty = (cfg_shadow.manual_duty > DUTY_FULL) ? DUTY_W'(DUTY_FULL)
                                                        : DUTY_W'(cfg_shadow.manual_duty);
         r.status = STATUS_MANUAL;
      end else begin
         // segments are tested in order; a divisor is positive whenever reached
         if (t < lo) begin
            r.duty = '0;
         end else if (t < mid) begin
            r.duty = DUTY_W'(((t - lo) * DUTY_HALF) / (mid - lo));
         end else if (t < hi) begin
            r.duty = DUTY_W'(DUTY_HALF + ((t - mid) * DUTY_HALF) / (hi - mid));
         end else begin
            r.duty = DUTY_W'(DUTY_FULL);
         end
         if (t >= crit) begin
            r.status = STATUS_CRITICAL;
         end else if (t >= mid) begin
            r.status = STATUS_WARNING;
         end else begin
            r.status = STATUS_NORMAL;
         end
      end
      return r;
   endfunction

   // Write one register; mirror it into the shadow with the block's masking.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         REG_THRESHOLD_LOW: begin
            cfg_shadow.threshold_low = data;
         end
         REG_THRESHOLD_MID: begin
            cfg_shadow.threshold_mid = data;
         end
         REG_THRESHOLD_HIGH: begin
            cfg_shadow.threshold_high = data;
         end
         REG_THRESHOLD_CRITICAL: begin
            cfg_shadow.threshold_critical = data;
         end
         REG_MANUAL_MODE: begin
            cfg_shadow.manual_mode = data[0];
         end
         REG_MANUAL_DUTY: begin
            cfg_shadow.manual_duty = data[MDUTY_W-1:0];
         end
         default: begin
            // past the list: dropped by the block
         end
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_config(input int lo, input int mid, input int hi, input int crit,
                             input bit manual, input int manual_pct);
      write_reg(REG_THRESHOLD_LOW, CSR_DATA_W'(lo));
      write_reg(REG_THRESHOLD_MID, CSR_DATA_W'(mid));
      write_reg(REG_THRESHOLD_HIGH, CSR_DATA_W'(hi));
      write_reg(REG_THRESHOLD_CRITICAL, CSR_DATA_W'(crit));
      write_reg(REG_MANUAL_MODE, CSR_DATA_W'(manual));
      write_reg(REG_MANUAL_DUTY, CSR_DATA_W'(manual_pct));
      settings_applied++;
   endtask

   // Send one sample beat after a random gap; predict its reading on accept.
   // Valid stays high afterwards so back-to-back beats need no toggle.
   task automatic send_sample(input logic [ADC_W-1:0] adc,
                              input logic signed [TEMP_W-1:0] itemp);
      int gap;
      gap = send_gaps ? $urandom_range(0, 5) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid        = 1'b1;
      req_chan.adc_raw      = adc;
      req_chan.int_temp_raw = itemp;
      do @(posedge clock); while (!req_chan.ready);
      pending_readings.push_back(predict_reading(adc, itemp));
      samples_sent++;
   endtask

   // Drop valid, wait for every predicted reading, then let the block settle.
   task automatic drain();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result side: stall for a random count per beat, then compare the beat
   // field by field with the oldest prediction.
   initial begin : result_checker
      int stall;
      fan_reading_type want;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         stall = recv_stalls ? $urandom_range(0, 5) : 0;
         @(negedge clock);
         if (stall > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         if (pending_readings.size() == 0) begin
            fail_count++;
            $error("result beat with no sample pending: ext %0d int %0d duty %0d status %0d",
                   rsp_chan.ext_temp_filtered, rsp_chan.int_temp_filtered,
                   rsp_chan.fan_duty, rsp_chan.status);
         end else begin
            want = pending_readings.pop_front();
            readings_checked++;
            if (rsp_chan.ext_temp_filtered !== want.ext_temp) begin
               fail_count++;
               $error("ext_temp_filtered: expected %0d, got %0d",
                      want.ext_temp, rsp_chan.ext_temp_filtered);
            end
            if (rsp_chan.int_temp_filtered !== want.int_temp) begin
               fail_count++;
               $error("int_temp_filtered: expected %0d, got %0d",
                      want.int_temp, rsp_chan.int_temp_filtered);
            end
            if (rsp_chan.fan_duty !== want.duty) begin
               fail_count++;
               $error("fan_duty: expected %0d, got %0d", want.duty, rsp_chan.fan_duty);
            end
            if (rsp_chan.status !== want.status) begin
               fail_count++;
               $error("status: expected %0d, got %0d", want.status, rsp_chan.status);
            end
         end
      end
   end

   // Default registers: hold the ADC at zero so the filtered external
   // temperature climbs from 25 C through every curve segment into critical,
   // then hit the extremes of both input fields.
   task automatic test_climb_and_extremes();
      repeat (8) send_sample('0, 18'sd125000);
      send_sample({ADC_W{1'b1}}, {1'b1, {(TEMP_W-1){1'b0}}});
      send_sample({ADC_W{1'b1}}, {1'b0, {(TEMP_W-1){1'b1}}});
      send_sample(12'h800, -18'sd40000);
      drain();
   endtask

   // Manual mode: duty above 100 clamps, 100 and 0 pass through. Then a mode
   // write with bit 0 clear returns to auto, and writes past the register list
   // must leave everything untouched.
   task automatic test_manual_duty();
      set_config(THR_LOW_RESET, THR_MID_RESET, THR_HIGH_RESET, THR_CRIT_RESET, 1'b1, 255);
      send_sample(12'h123, 18'sd1000);
      drain();
      write_reg(REG_MANUAL_DUTY, CSR_DATA_W'(DUTY_FULL));
      send_sample(12'h456, 18'sd2000);
      drain();
      write_reg(REG_MANUAL_DUTY, CSR_DATA_W'(DUTY_FULL + 1));
      send_sample(12'h789, 18'sd3000);
      drain();
      write_reg(REG_MANUAL_DUTY, '0);
      send_sample('0, 18'sd4000);
      drain();
      write_reg(REG_MANUAL_MODE, 19'h7fffe);
      write_reg(REG_SPARE_LO, {CSR_DATA_W{1'b1}});
      write_reg(REG_SPARE_HI, '0);
      send_sample('0, -18'sd4000);
      drain();
   endtask

   // Reversed, equal and extreme thresholds: segments get skipped, duty must
   // still land within 0..100.
   task automatic test_threshold_order();
      set_config(60000, 45000, 30000, 20000, 1'b0, 0);
      send_sample('0, 18'sd50000);
      send_sample({ADC_W{1'b1}}, 18'sd50000);
      drain();
      set_config(50000, 50000, 50000, 50000, 1'b0, 0);
      send_sample('0, 18'sd0);
      send_sample({ADC_W{1'b1}}, 18'sd0);
      drain();
      set_config(THR_MIN, THR_MAX, THR_MAX, THR_MIN, 1'b0, 0);
      send_sample(12'h400, 18'sd0);
      drain();
      set_config(THR_MAX, THR_MIN, THR_MIN, THR_MAX, 1'b0, 0);
      send_sample(12'hc00, 18'sd0);
      drain();
   endtask

   // Random phases: reprogram while idle, then send runs of samples. Most
   // runs hold the ADC near a target so the filter settles and crosses the
   // thresholds; the rest are noise over the full code range.
   task automatic test_random_phases();
      int phase;
      int sent;
      int run_len;
      int kind;
      int adc_target;
      int int_target;
      int a;
      int v0;
      int v1;
      int v2;
      int tmp;
      bit adc_noise;
      bit int_noise;
      logic signed [TEMP_W-1:0] itemp;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            set_config($urandom_range(0, 1) ? THR_MAX : THR_MIN,
                       $urandom_range(0, 1) ? THR_MAX : THR_MIN,
                       $urandom_range(0, 1) ? THR_MAX : THR_MIN,
                       $urandom_range(0, 1) ? THR_MAX : THR_MIN,
                       1'b0, $urandom_range(0, 1) ? 255 : 0);
         end else if (kind == 1) begin
            set_config($urandom, $urandom, $urandom, $urandom, 1'b0, $urandom_range(0, 255));
         end else if (kind == 2) begin
            set_config($urandom, $urandom, $urandom, $urandom, 1'b1, $urandom_range(0, 255));
         end else begin
            // ascending low, mid and high thresholds spanning the reachable external range
            v0 = $urandom_range(20000, 130000);
            v1 = $urandom_range(20000, 130000);
            v2 = $urandom_range(20000, 130000);
            if (v0 > v1) begin tmp = v0; v0 = v1; v1 = tmp; end
            if (v1 > v2) begin tmp = v1; v1 = v2; v2 = tmp; end
            if (v0 > v1) begin tmp = v0; v0 = v1; v1 = tmp; end
            set_config(v0, v1, v2, $urandom_range(20000, 130000), 1'b0,
                       $urandom_range(0, 255));
         end
         // leave some phases free of gaps and stalls
         send_gaps   = ($urandom_range(0, 3) != 0);
         recv_stalls = ($urandom_range(0, 3) != 0);
         sent = 0;
         while (sent < PHASE_SAMPLES) begin
            run_len    = $urandom_range(5, 30);
            adc_noise  = ($urandom_range(0, 4) == 0);
            int_noise  = ($urandom_range(0, 2) == 0);
            adc_target = $urandom_range(0, 4095);
            int_target = int'($urandom_range(0, 165000)) - 40000;
            repeat (run_len) begin
               if (adc_noise) begin
                  a = $urandom_range(0, 4095);
               end else begin
                  a = adc_target + int'($urandom_range(0, 128)) - 64;
                  if (a < 0) a = 0;
                  if (a > 4095) a = 4095;
               end
               if (int_noise) begin
                  itemp = TEMP_W'($urandom);
               end else begin
                  itemp = TEMP_W'(int_target + int'($urandom_range(0, 2000)) - 1000);
               end
               send_sample(ADC_W'(a), itemp);
               sent++;
            end
         end
      end
      drain();
   endtask

   initial begin
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = '0;
      csr_wdata             = '0;
      req_chan.valid        = 1'b0;
      req_chan.adc_raw      = '0;
      req_chan.int_temp_raw = '0;
      rsp_chan.ready        = 1'b0;
      send_gaps             = 1'b1;
      recv_stalls           = 1'b1;
      fail_count            = 0;
      samples_sent          = 0;
      readings_checked      = 0;
      settings_applied      = 0;
      // shadow starts from the block's reset values
      cfg_shadow.threshold_low      = THR_LOW_RESET;
      cfg_shadow.threshold_mid      = THR_MID_RESET;
      cfg_shadow.threshold_high     = THR_HIGH_RESET;
      cfg_shadow.threshold_critical = THR_CRIT_RESET;
      cfg_shadow.manual_mode        = 1'b0;
      cfg_shadow.manual_duty        = '0;
      ext_acc_shadow                = TEMP_W'(ACC_RESET);
      int_acc_shadow                = TEMP_W'(ACC_RESET);

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_climb_and_extremes();
      test_manual_duty();
      test_threshold_order();
      test_random_phases();

      $display("Checked %0d result beats for %0d samples across %0d register settings.",
               readings_checked, samples_sent, settings_applied);
      $display("Directed: curve climb, field extremes, manual clamp, odd thresholds;");
      $display("then %0d random phases with gaps and stalls.", RANDOM_PHASES);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Hard stop if the block hangs
   initial begin : watchdog
      #(RUN_LIMIT);
      $display("timeout with %0d readings still pending", pending_readings.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire

### sim.f
hdl/tffc_pkg.sv
hdl/tffc_req_if.sv
hdl/tffc_rsp_if.sv
hdl/tffc_regs.sv
hdl/tffc_ctrl.sv
hdl/tffc_dp.sv
hdl/thermal_filter_fan_curve.sv
tb/sv/thermal_filter_fan_curve_test.sv
